// File: design/particle_state_update_macros.svh
// Assertion macros for the particle state update block.
`ifndef PARTICLE_STATE_UPDATE_MACROS_SVH
`define PARTICLE_STATE_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/psu_pkg.sv
// Shared types, constants and colour tables of the particle state update block.
package psu_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 2'd2;

    localparam logic [2:0] KIND_STATIC   = 3'd0;
    localparam logic [2:0] KIND_GRAV     = 3'd1;
    localparam logic [2:0] KIND_SLOWGRAV = 3'd2;
    localparam logic [2:0] KIND_FIRE     = 3'd3;
    localparam logic [2:0] KIND_EXPLODE  = 3'd4;
    localparam logic [2:0] KIND_EXPLODE2 = 3'd5;
    localparam logic [2:0] KIND_BLOB     = 3'd6;
    localparam logic [2:0] KIND_BLOB2    = 3'd7;

    localparam logic [3:0] FIRE_RATE     = 4'd5;
    localparam logic [3:0] EXPLODE_RATE  = 4'd10;
    localparam logic [3:0] EXPLODE2_RATE = 4'd15;

    localparam logic [11:0] GRAVITY_RESET = 12'd800;
    // gravity step = floor(F * gravity / 5120) = floor((F * gravity >> 10) / 5)
    localparam int          GRAV_SHIFT   = 10;
    localparam logic [13:0] RECIP_5      = 14'd13107;  // floor(65536 / 5), under by < 1
    localparam logic [31:0] DIE_EXPIRED  = 32'hFFFF_0000;

    typedef struct packed {
        logic             keep;
        logic [2:0]       kind;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [15:0]      ramp;
        logic [7:0]       pal;
        logic [31:0]      die;
        logic [30:0]      spawn;
    } psu_rec_t;

    typedef struct packed {
        logic [15:0] frame_time;
        logic [15:0] grav_step;
    } psu_cfg_t;

    function automatic logic [7:0] tab_fire(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h6d;
            3'd1:    v = 8'h6b;
            3'd2:    v = 8'h06;
            3'd3:    v = 8'h05;
            3'd4:    v = 8'h04;
            3'd5:    v = 8'h03;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] tab_explode(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h6f;
            3'd1:    v = 8'h6d;
            3'd2:    v = 8'h6b;
            3'd3:    v = 8'h69;
            3'd4:    v = 8'h67;
            3'd5:    v = 8'h65;
            3'd6:    v = 8'h63;
            default: v = 8'h61;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] tab_explode2(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h6f;
            3'd1:    v = 8'h6e;
            3'd2:    v = 8'h6d;
            3'd3:    v = 8'h6c;
            3'd4:    v = 8'h6b;
            3'd5:    v = 8'h6a;
            3'd6:    v = 8'h68;
            default: v = 8'h66;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] x);
        logic [31:0] r;
        if (x[35:31] == 5'b00000 || x[35:31] == 5'b11111)
            r = x[31:0];
        else if (x[35])
            r = 32'h8000_0000;
        else
            r = 32'h7fff_ffff;
        return r;
    endfunction

endpackage

// File: design/psu_front.sv
// Front end: configuration registers, gravity step, liveness and colour ramp.
module psu_front
    import psu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psu_rec_t             in_rec,
    output logic                 fr_valid,
    input  logic                 fr_ready,
    output psu_rec_t             fr_rec,
    output psu_cfg_t             cfg
);

    logic [30:0] cur_time_reg;
    logic [15:0] frame_time_reg;
    logic [11:0] gravity_reg;
    logic [27:0] gprod_reg;
    logic [17:0] gq_reg;
    logic [15:0] gest_reg;
    logic [15:0] gstep_reg;

    logic [31:0] gest_prod;
    logic [18:0] gest_x5;
    logic [17:0] grem;

    logic        fr_valid_reg, fr_valid_next;
    psu_rec_t    fr_rec_reg, fr_rec_next;

    logic        live;
    logic [3:0]  rate;
    logic [19:0] step_prod;
    logic [16:0] ramp_sum;
    logic [15:0] ramp_new;
    logic        ramp_end;
    logic [7:0]  pal_new;
    logic        is_ramp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg   <= '0;
            frame_time_reg <= '0;
            gravity_reg    <= GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CURRENT_TIME: cur_time_reg   <= cfg_wdata;
                CFG_FRAME_TIME:   frame_time_reg <= cfg_wdata[15:0];
                CFG_GRAVITY:      gravity_reg    <= cfg_wdata[11:0];
                default:          ;
            endcase
        end
    end

    // gravity step, registered through gprod_reg, gq_reg/gest_reg and gstep_reg
    assign gest_prod = gprod_reg[27:GRAV_SHIFT] * RECIP_5;
    assign gest_x5   = {gest_reg, 2'b00} + {3'b000, gest_reg};
    assign grem      = gq_reg - gest_x5[17:0];

    always_ff @(posedge clk)
    begin
        gprod_reg <= frame_time_reg * gravity_reg;
        gq_reg    <= gprod_reg[27:GRAV_SHIFT];
        gest_reg  <= gest_prod[31:16];
        gstep_reg <= (grem >= 18'd5) ? gest_reg + 16'd1 : gest_reg;
    end

    assign cfg.frame_time = frame_time_reg;
    assign cfg.grav_step  = gstep_reg;

    always_comb
    begin
        live = !(($signed(in_rec.die) < $signed({1'b0, cur_time_reg}))
                 || (in_rec.spawn > cur_time_reg));

        case (in_rec.kind)
            KIND_FIRE:     rate = FIRE_RATE;
            KIND_EXPLODE:  rate = EXPLODE_RATE;
            KIND_EXPLODE2: rate = EXPLODE2_RATE;
            default:       rate = 4'd0;
        endcase
        is_ramp = (rate != 4'd0);

        step_prod = frame_time_reg * rate;
        ramp_sum  = {1'b0, in_rec.ramp} + {1'b0, step_prod[19:4]};
        ramp_new  = ramp_sum[16] ? 16'hffff : ramp_sum[15:0];

        case (in_rec.kind)
            KIND_FIRE:
            begin
                ramp_end = (ramp_new[15:12] >= 4'd6);
                pal_new  = tab_fire(ramp_new[14:12]);
            end
            KIND_EXPLODE:
            begin
                ramp_end = ramp_new[15];
                pal_new  = tab_explode(ramp_new[14:12]);
            end
            default:
            begin
                ramp_end = ramp_new[15];
                pal_new  = tab_explode2(ramp_new[14:12]);
            end
        endcase

        fr_rec_next      = in_rec;
        fr_rec_next.keep = live;
        if (live && is_ramp)
        begin
            fr_rec_next.ramp = ramp_new;
            if (ramp_end)
                fr_rec_next.die = DIE_EXPIRED;
            else
                fr_rec_next.pal = pal_new;
        end
    end

    assign in_ready = !fr_valid_reg || fr_ready;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (in_valid && in_ready)
            fr_valid_next = 1'b1;
        else if (fr_ready)
            fr_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            fr_rec_reg <= fr_rec_next;
    end

    assign fr_valid = fr_valid_reg;
    assign fr_rec   = fr_rec_reg;

endmodule

// File: design/psu_queue.sv
// Short word queue between the front end and the motion pipeline.
module psu_queue
    import psu_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int LW    = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  psu_rec_t      push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output psu_rec_t      pop_data,
    output logic [LW-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    psu_rec_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != LW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];
    assign level      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + LW'(push) - LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: design/psu_back.sv
// Motion pipeline: velocity products, position move, kind rules, gravity.
module psu_back
    import psu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  psu_cfg_t cfg,
    input  logic     q_valid,
    output logic     q_ready,
    input  psu_rec_t q_rec,
    output logic     out_valid,
    input  logic     out_ready,
    output psu_rec_t out_rec
);

    logic            v1_reg, v2_reg, v3_reg;
    logic            en1, en2, en3;
    psu_rec_t        r1_reg, r2_reg, r3_reg;
    psu_rec_t        r2_next, r3_next;
    logic signed [48:0] prod_reg  [3];
    logic signed [48:0] prod_next [3];

    logic signed [32:0] sh16 [3];
    logic signed [34:0] sh14 [3];
    logic signed [35:0] pos_w, vel_w, pos_sum, grow, damp16, damp14;
    logic signed [35:0] vz_w, g_w, vz_sum;

    assign en3     = !v3_reg || out_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign q_ready = en1;

    // stage 1: vel * F on each axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod_next[i] = $signed(q_rec.vel[i]) * $signed({1'b0, cfg.frame_time});
    end

    // stage 2: move, then growth or damping
    always_comb
    begin
        r2_next = r1_reg;
        for (int i = 0; i < 3; i++)
        begin
            sh16[i] = prod_reg[i][48:16];
            sh14[i] = prod_reg[i][48:14];
            pos_w   = 36'($signed(r1_reg.pos[i]));
            vel_w   = 36'($signed(r1_reg.vel[i]));
            pos_sum = pos_w + 36'(sh16[i]);
            grow    = vel_w + 36'(sh14[i]);
            damp16  = vel_w - 36'(sh16[i]);
            damp14  = vel_w - 36'(sh14[i]);
            if (r1_reg.keep)
            begin
                r2_next.pos[i] = sat32(pos_sum);
                case (r1_reg.kind)
                    KIND_EXPLODE, KIND_BLOB: r2_next.vel[i] = sat32(grow);
                    KIND_EXPLODE2:           r2_next.vel[i] = sat32(damp16);
                    KIND_BLOB2:
                    begin
                        if (i != 2)
                            r2_next.vel[i] = sat32(damp14);
                    end
                    default:                 ;
                endcase
            end
        end
    end

    // stage 3: gravity on z, lift for fire
    always_comb
    begin
        r3_next = r2_reg;
        vz_w    = 36'($signed(r2_reg.vel[2]));
        g_w     = $signed({20'b0, cfg.grav_step});
        if (r2_reg.kind == KIND_FIRE)
            vz_sum = vz_w + g_w;
        else
            vz_sum = vz_w - g_w;
        if (r2_reg.keep && r2_reg.kind != KIND_STATIC)
            r3_next.vel[2] = sat32(vz_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= q_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            r1_reg <= q_rec;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= prod_next[i];
        end
        if (en2)
            r2_reg <= r2_next;
        if (en3)
            r3_reg <= r3_next;
    end

    assign out_valid = v3_reg;
    assign out_rec   = r3_reg;

endmodule

// File: design/particle_state_update.sv
// Top level of the particle state update block: stream ports and assertions.
//
// Takes one particle record per clock while s_axis_tready is high and returns its
// per-frame update, one word in, one word out, in order. A word passes the front
// end register (liveness check and colour ramp), the queue and the three-stage
// motion pipeline (velocity products, move and kind rule, gravity); it is held in
// fr_rec_reg, the queue memory, r1_reg, r2_reg and r3_reg before it is valid on
// m_axis. The output register decouples the downstream side and a stall there
// backs up through the queue to s_axis_tready.
// The gravity step is derived from frame_time and gravity after a configuration
// write through gprod_reg, gest_reg and gstep_reg; no reset sweep is needed.
`include "particle_state_update_macros.svh"

module particle_state_update
    import psu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]          cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_phase, palette_index,
    // die_time, spawn_time, zero pad
    input  logic [279:0]         s_axis_tdata,
    // kind
    input  logic [2:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_ramp_phase, new_palette_index, new_die_time, spawn_time_out, zero pad
    output logic [279:0]         m_axis_tdata,
    // keep, kind_out
    output logic [3:0]           m_axis_tuser
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    psu_rec_t      in_rec, fr_rec, q_rec, out_rec;
    psu_cfg_t      cfg;
    logic          fr_valid, fr_ready;
    logic          q_valid, q_ready;
    logic [LW-1:0] q_level;

    always_comb
    begin
        in_rec.keep   = 1'b0;
        in_rec.kind   = s_axis_tuser;
        in_rec.pos    = s_axis_tdata[95:0];
        in_rec.vel    = s_axis_tdata[191:96];
        in_rec.ramp   = s_axis_tdata[207:192];
        in_rec.pal    = s_axis_tdata[215:208];
        in_rec.die    = s_axis_tdata[247:216];
        in_rec.spawn  = s_axis_tdata[278:248];
    end

    psu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_rec    (in_rec),
        .fr_valid  (fr_valid),
        .fr_ready  (fr_ready),
        .fr_rec    (fr_rec),
        .cfg       (cfg)
    );

    psu_queue #(
        .DEPTH (QUEUE_DEPTH),
        .LW    (LW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_rec),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_rec),
        .level      (q_level)
    );

    psu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_rec     (q_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tdata = {1'b0, out_rec.spawn, out_rec.die, out_rec.pal, out_rec.ramp,
                           out_rec.vel, out_rec.pos};
    assign m_axis_tuser = {out_rec.kind, out_rec.keep};

    `PSU_ASSERT_IMPL(a_queue_bound, 1'b1, q_level <= LW'(QUEUE_DEPTH), "queue overfilled")
    `PSU_ASSERT_NEXT(a_queue_track, 1'b1,
        q_level == $past(q_level) + LW'($past(fr_valid && fr_ready))
                   - LW'($past(q_valid && q_ready)), "queue level mismatch")
    `PSU_ASSERT_NEXT(a_front_hold, fr_valid && !fr_ready,
        fr_valid && $stable(fr_rec), "front word lost while queue full")

endmodule
